// ===== sv/raabb_pkg.sv =====
// ----------------------------------------------------------------------------
// Ray/box intersection package
// Shared defaults, register indexes and face lookup tables.
// ----------------------------------------------------------------------------
package raabb_pkg;

  // Default word layout: signed Q16.16.
  localparam int COORD_BITS_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;

  // Quotient bits resolved in each divider stage.
  localparam int DIV_STEPS_PER_STAGE = 4;

  // Configuration register indexes.
  localparam int CFG_IDX_BITS = 3;
  localparam logic [CFG_IDX_BITS-1:0] REG_BOX_MIN_X = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_BOX_MIN_Y = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_BOX_MIN_Z = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_BOX_MAX_X = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_BOX_MAX_Y = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_BOX_MAX_Z = 3'd5;

  // Face f lies on axis FACE_AXIS[f]; FACE_SIDE[f] selects the upper corner.
  localparam int FACE_AXIS [6] = '{0, 0, 1, 1, 2, 2};
  localparam int FACE_SIDE [6] = '{0, 1, 0, 1, 0, 1};

  // The two axes checked on a face of a given axis.
  localparam int OTHER_AXIS [3][2] = '{'{1, 2}, '{2, 0}, '{0, 1}};

endpackage

// ===== sv/ray_aabb_intersect.sv =====
// ----------------------------------------------------------------------------
// Ray against axis-aligned box intersection
// The divider is a pipelined restoring divider that resolves four quotient
// bits per stage for all six faces in parallel.
// Throughput: one ray per cycle while the output is not stalled; a stalled
// output holds only the stages that are full. Reset clears all stage valid
// bits and the box registers.
// ----------------------------------------------------------------------------
module ray_aabb_intersect
  import raabb_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // Configuration write port
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0] cfg_idx_i,
  input  logic [COORD_BITS-1:0]   cfg_data_i,
  // Ray input channel
  input  logic                    valid_i,
  output logic                    stall_o,
  input  logic [COORD_BITS-1:0]   origin_x_i,
  input  logic [COORD_BITS-1:0]   origin_y_i,
  input  logic [COORD_BITS-1:0]   origin_z_i,
  input  logic [COORD_BITS-1:0]   dir_x_i,
  input  logic [COORD_BITS-1:0]   dir_y_i,
  input  logic [COORD_BITS-1:0]   dir_z_i,
  input  logic [COORD_BITS-1:0]   hit_min_in_i,
  input  logic [COORD_BITS-1:0]   hit_max_in_i,
  // Result channel
  output logic                    valid_o,
  input  logic                    stall_i,
  output logic                    hit_o,
  output logic [COORD_BITS-1:0]   hit_min_out_o,
  output logic [COORD_BITS-1:0]   hit_max_out_o
);

  localparam int W   = COORD_BITS;
  localparam int F   = FRAC_BITS;
  localparam int SPS = DIV_STEPS_PER_STAGE;
  localparam int DS  = (W - 1 + SPS - 1) / SPS;
  localparam int DW  = W + 1 + F;
  localparam int CW  = (W > F + 2) ? W : F + 2;
  localparam int PW  = 2 * W - 1;

  localparam int S_IN   = 0;
  localparam int S_PREP = 1;
  localparam int S_DIV0 = 2;
  localparam int S_MUL  = 2 + DS;
  localparam int S_QM   = 3 + DS;
  localparam int S_CHK  = 4 + DS;
  localparam int S_RED  = 5 + DS;
  localparam int S_OUT  = 6 + DS;
  localparam int NSTG   = 7 + DS;

  localparam logic [W-1:0]  QMAX_W = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0]  QMIN_W = {1'b1, {(W-1){1'b0}}};
  localparam logic [PW-1:0] LIM_POS = PW'(QMAX_W);
  localparam logic [PW-1:0] LIM_NEG = PW'(QMAX_W) + PW'(1);

  typedef logic [W-1:0] word_t;

  typedef struct packed {
    word_t [2:0] org;
    word_t [2:0] dir;
    word_t       hmin;
    word_t       hmax;
  } raw_t;

  typedef struct packed {
    word_t [2:0] org;
    word_t [2:0] magd;
    logic  [2:0] dneg;
    word_t       hmin;
    word_t       hmax;
    logic        in_box;
  } ray_t;

  typedef struct packed {
    ray_t              ray;
    logic [5:0][W:0]   magnum;
    logic [5:0]        fok;
  } prep_t;

  typedef struct packed {
    logic [W-1:0] rem;
    logic [W-2:0] low;
    logic [W-2:0] quo;
    logic         sat;
    logic         fok;
  } div_t;

  typedef struct packed {
    ray_t       ray;
    div_t [5:0] dv;
  } dstg_t;

  typedef struct packed {
    ray_t                   ray;
    logic [5:0][W-2:0]      tq;
    logic [5:0]             fok;
    logic [5:0][1:0][PW-1:0] prod;
  } mul_t;

  typedef struct packed {
    ray_t                  ray;
    logic [5:0][W-2:0]     tq;
    logic [5:0]            fok;
    logic [5:0][1:0][W-1:0] qv;
  } qm_t;

  typedef struct packed {
    ray_t              ray;
    logic [5:0][W-2:0] tq;
    logic [5:0]        ok;
  } chk_t;

  typedef struct packed {
    logic [W-2:0] nearv;
    logic [W-2:0] farv;
    word_t        hmin;
    word_t        hmax;
  } red_t;

  // One restoring division step: shift in a dividend bit, subtract if it fits.
  function automatic div_t div_step(div_t x, logic [W-1:0] b);
    logic [W:0] t;
    logic [W:0] diff;
    div_t       y;
    y    = x;
    t    = {x.rem, x.low[W-2]};
    diff = t - {1'b0, b};
    if (t >= {1'b0, b}) begin
      y.rem = diff[W-1:0];
      y.quo = {x.quo[W-3:0], 1'b1};
    end else begin
      y.rem = t[W-1:0];
      y.quo = {x.quo[W-3:0], 1'b0};
    end
    y.low = {x.low[W-3:0], 1'b0};
    return y;
  endfunction

  function automatic logic [W-2:0] umin(logic [W-2:0] a, logic [W-2:0] b);
    return (a < b) ? a : b;
  endfunction

  function automatic logic [W-2:0] umax(logic [W-2:0] a, logic [W-2:0] b);
    return (a > b) ? a : b;
  endfunction

  // Box corner registers.
  logic [2:0][W-1:0] box_lo_q, box_hi_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      box_lo_q <= '0;
      box_hi_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_BOX_MIN_X: box_lo_q[0] <= cfg_data_i;
        REG_BOX_MIN_Y: box_lo_q[1] <= cfg_data_i;
        REG_BOX_MIN_Z: box_lo_q[2] <= cfg_data_i;
        REG_BOX_MAX_X: box_hi_q[0] <= cfg_data_i;
        REG_BOX_MAX_Y: box_hi_q[1] <= cfg_data_i;
        REG_BOX_MAX_Z: box_hi_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Stage valid bits and the ready chain: a stage moves when it is empty or
  // the stage after it moves.
  logic [NSTG-1:0] vld_q;
  logic [NSTG:0]   adv;

  always_comb begin
    adv[NSTG] = !stall_i;
    for (int s = NSTG - 1; s >= 0; s--) begin
      adv[s] = !vld_q[s] || adv[s+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (adv[0]) begin
        vld_q[0] <= valid_i;
      end
      for (int s = 1; s < NSTG; s++) begin
        if (adv[s]) begin
          vld_q[s] <= vld_q[s-1];
        end
      end
    end
  end

  assign stall_o = !adv[0];

  // Input register.
  raw_t in_q;

  always_ff @(posedge clk_i) begin
    if (adv[S_IN] && valid_i) begin
      in_q.org  <= {origin_z_i, origin_y_i, origin_x_i};
      in_q.dir  <= {dir_z_i, dir_y_i, dir_x_i};
      in_q.hmin <= hit_min_in_i;
      in_q.hmax <= hit_max_in_i;
    end
  end

  // Face numerators, magnitudes, sign checks and the inside test.
  prep_t prep_d, prep_q;

  always_comb begin
    logic [W:0]   num;
    logic [W:0]   o_ext;
    logic [W-1:0] face;
    int           ax;
    prep_d.ray.org  = in_q.org;
    prep_d.ray.hmin = in_q.hmin;
    prep_d.ray.hmax = in_q.hmax;
    prep_d.ray.in_box = 1'b1;
    for (int a = 0; a < 3; a++) begin
      prep_d.ray.dneg[a] = in_q.dir[a][W-1];
      prep_d.ray.magd[a] = in_q.dir[a][W-1] ? W'(-in_q.dir[a]) : in_q.dir[a];
      if ($signed(in_q.org[a]) < $signed(box_lo_q[a]) ||
          $signed(in_q.org[a]) > $signed(box_hi_q[a])) begin
        prep_d.ray.in_box = 1'b0;
      end
    end
    for (int f = 0; f < 6; f++) begin
      ax    = FACE_AXIS[f];
      face  = (FACE_SIDE[f] != 0) ? box_hi_q[ax] : box_lo_q[ax];
      o_ext = {in_q.org[ax][W-1], in_q.org[ax]};
      num   = {face[W-1], face} - o_ext;
      prep_d.magnum[f] = num[W] ? (W+1)'(-num) : num;
      prep_d.fok[f] = (in_q.dir[ax] != '0) &&
                      ((num == '0) || (num[W] == in_q.dir[ax][W-1]));
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[S_PREP] && vld_q[S_IN]) begin
      prep_q <= prep_d;
    end
  end

  // Divider setup: upper dividend bits form the first remainder; a first
  // remainder not below the divisor means the quotient saturates.
  dstg_t div_init;

  always_comb begin
    logic [DW-1:0] dvd;
    logic [CW-1:0] topc;
    logic [CW-1:0] bc;
    div_init.ray = prep_q.ray;
    for (int f = 0; f < 6; f++) begin
      dvd  = {prep_q.magnum[f], {F{1'b0}}};
      topc = CW'(dvd[DW-1:W-1]);
      bc   = CW'(prep_q.ray.magd[FACE_AXIS[f]]);
      div_init.dv[f].sat = (topc >= bc);
      div_init.dv[f].rem = topc[W-1:0];
      div_init.dv[f].low = dvd[W-2:0];
      div_init.dv[f].quo = '0;
      div_init.dv[f].fok = prep_q.fok[f];
    end
  end

  // Divider stages, up to SPS quotient bits each.
  dstg_t [DS-1:0] dstg_q;
  dstg_t [DS-1:0] dstg_d;

  for (genvar j = 0; j < DS; j++) begin : g_div
    always_comb begin
      dstg_d[j] = (j == 0) ? div_init : dstg_q[(j == 0) ? 0 : j-1];
      for (int i = 0; i < SPS; i++) begin
        if (j * SPS + i < W - 1) begin
          for (int f = 0; f < 6; f++) begin
            dstg_d[j].dv[f] = div_step(dstg_d[j].dv[f],
                                       dstg_d[j].ray.magd[FACE_AXIS[f]]);
          end
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv[S_DIV0+j] && vld_q[S_DIV0+j-1]) begin
        dstg_q[j] <= dstg_d[j];
      end
    end
  end

  // Hit point products: |direction| times the face distance.
  mul_t mul_d, mul_q;

  always_comb begin
    logic [W-2:0] t;
    mul_d.ray = dstg_q[DS-1].ray;
    for (int f = 0; f < 6; f++) begin
      t = dstg_q[DS-1].dv[f].sat ? {(W-1){1'b1}} : dstg_q[DS-1].dv[f].quo;
      mul_d.tq[f]  = t;
      mul_d.fok[f] = dstg_q[DS-1].dv[f].fok;
      for (int n = 0; n < 2; n++) begin
        mul_d.prod[f][n] =
          PW'(dstg_q[DS-1].ray.magd[OTHER_AXIS[FACE_AXIS[f]][n]]) * PW'(t);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[S_MUL] && vld_q[S_MUL-1]) begin
      mul_q <= mul_d;
    end
  end

  // Scale the products back to the word and saturate with the sign restored.
  qm_t qm_d, qm_q;

  always_comb begin
    logic [PW-1:0] m;
    logic [PW-1:0] neg_m;
    int            k;
    qm_d.ray = mul_q.ray;
    qm_d.tq  = mul_q.tq;
    qm_d.fok = mul_q.fok;
    for (int f = 0; f < 6; f++) begin
      for (int n = 0; n < 2; n++) begin
        k     = OTHER_AXIS[FACE_AXIS[f]][n];
        m     = mul_q.prod[f][n] >> F;
        neg_m = PW'(0) - m;
        if (mul_q.ray.dneg[k]) begin
          qm_d.qv[f][n] = (m > LIM_NEG) ? QMIN_W : neg_m[W-1:0];
        end else begin
          qm_d.qv[f][n] = (m > LIM_POS) ? QMAX_W : m[W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[S_QM] && vld_q[S_QM-1]) begin
      qm_q <= qm_d;
    end
  end

  // Hit point on each face and the inclusive face bounds test.
  chk_t chk_d, chk_q;

  always_comb begin
    logic [W:0]   sum;
    logic [W-1:0] p;
    int           k;
    chk_d.ray = qm_q.ray;
    chk_d.tq  = qm_q.tq;
    for (int f = 0; f < 6; f++) begin
      chk_d.ok[f] = qm_q.fok[f];
      for (int n = 0; n < 2; n++) begin
        k   = OTHER_AXIS[FACE_AXIS[f]][n];
        sum = {qm_q.ray.org[k][W-1], qm_q.ray.org[k]} +
              {qm_q.qv[f][n][W-1], qm_q.qv[f][n]};
        if (sum[W] != sum[W-1]) begin
          p = sum[W] ? QMIN_W : QMAX_W;
        end else begin
          p = sum[W-1:0];
        end
        if ($signed(p) < $signed(box_lo_q[k]) || $signed(p) > $signed(box_hi_q[k])) begin
          chk_d.ok[f] = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[S_CHK] && vld_q[S_CHK-1]) begin
      chk_q <= chk_d;
    end
  end

  // Near and far distances over the accepted faces, as a compare tree; near is zero for an origin inside the box.
  red_t red_d, red_q;

  always_comb begin
    logic [5:0][W-2:0] cn;
    logic [5:0][W-2:0] cf;
    for (int f = 0; f < 6; f++) begin
      cn[f] = chk_q.ok[f] ? chk_q.tq[f] : {(W-1){1'b1}};
      cf[f] = chk_q.ok[f] ? chk_q.tq[f] : '0;
    end
    red_d.nearv = umin(umin(umin(cn[0], cn[1]), umin(cn[2], cn[3])), umin(cn[4], cn[5]));
    red_d.farv  = umax(umax(umax(cf[0], cf[1]), umax(cf[2], cf[3])), umax(cf[4], cf[5]));
    if (chk_q.ray.in_box) begin
      red_d.nearv = '0;
    end
    red_d.hmin = chk_q.ray.hmin;
    red_d.hmax = chk_q.ray.hmax;
  end

  always_ff @(posedge clk_i) begin
    if (adv[S_RED] && vld_q[S_RED-1]) begin
      red_q <= red_d;
    end
  end

  // Interval clipping into the output register.
  logic  hit_d, hit_q;
  word_t hmin_d, hmax_d, hmin_q, hmax_q;

  always_comb begin
    word_t near_w;
    word_t far_w;
    logic  miss;
    near_w = {1'b0, red_q.nearv};
    far_w  = {1'b0, red_q.farv};
    miss   = (red_q.farv == '0);
    if (miss) begin
      hmin_d = red_q.hmin;
      hmax_d = red_q.hmax;
    end else begin
      hmin_d = ($signed(near_w) > $signed(red_q.hmin)) ? near_w : red_q.hmin;
      hmax_d = ($signed(far_w) < $signed(red_q.hmax)) ? far_w : red_q.hmax;
    end
    hit_d = !miss && ($signed(hmin_d) < $signed(hmax_d));
  end

  always_ff @(posedge clk_i) begin
    if (adv[S_OUT] && vld_q[S_OUT-1]) begin
      hit_q  <= hit_d;
      hmin_q <= hmin_d;
      hmax_q <= hmax_d;
    end
  end

  assign valid_o       = vld_q[NSTG-1];
  assign hit_o         = hit_q;
  assign hit_min_out_o = hmin_q;
  assign hit_max_out_o = hmax_q;

endmodule

// ===== sv/raabb_chk.sv =====
// ----------------------------------------------------------------------------
// Ray/box intersection checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module raabb_chk
  import raabb_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  stall_o,
  input logic                  valid_o,
  input logic                  stall_i,
  input logic                  hit_o,
  input logic [COORD_BITS-1:0] hit_min_out_o,
  input logic [COORD_BITS-1:0] hit_max_out_o
);

  // A stalled result transaction stays in place.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && stall_i |=> valid_o && $stable(hit_o) &&
    $stable(hit_min_out_o) && $stable(hit_max_out_o))
    else $error("stalled result changed");

  // A hit always reports a nonempty clipped interval.
  a_hit_interval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && hit_o |-> $signed(hit_min_out_o) < $signed(hit_max_out_o))
    else $error("hit with empty interval");

  // With no result waiting the pipeline can always take a ray.
  a_no_false_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !valid_o |-> !stall_o)
    else $error("input stalled with empty output");

  // An unstalled pipeline never holds back the input.
  a_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !stall_i |-> !stall_o)
    else $error("input stalled while output flows");

endmodule

bind ray_aabb_intersect raabb_chk #(.COORD_BITS(COORD_BITS)) u_raabb_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .stall_o      (stall_o),
  .valid_o      (valid_o),
  .stall_i      (stall_i),
  .hit_o        (hit_o),
  .hit_min_out_o(hit_min_out_o),
  .hit_max_out_o(hit_max_out_o)
);
